// File: src/u2u_pkg.sv
package u2u_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned UnitW  = 16;
	localparam int unsigned ValueW = 21;
	localparam int unsigned ContW  = 6;

	localparam logic [ByteW-1:0] LeadTwoMin  = 8'h80;
	localparam logic [ByteW-1:0] LeadThreeMin = 8'hE0;
	localparam logic [ByteW-1:0] LeadFourMin = 8'hF0;
	localparam logic [ByteW-1:0] ContMask    = 8'h3F;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_ONE   = 2'd1,
		PEND_TWO   = 2'd2,
		PEND_THREE = 2'd3
	} pend_t;

	typedef struct packed {
		logic [ByteW-1:0] in_byte;
		logic             string_start;
	} in_item_t;

	typedef struct packed {
		logic [UnitW-1:0] code_unit;
		logic             out_of_range;
	} out_item_t;

	// Item waiting in the input register, as seen by the decoder.
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

	// Decoder result toward the output register.
	typedef struct packed {
		logic      load;
		out_item_t item;
	} result_t;

endpackage

// File: src/u2u_in_if.sv
interface u2u_in_if;
	logic                      valid;
	logic                      ready;
	logic [u2u_pkg::ByteW-1:0] in_byte;
	logic                      string_start;

	modport source (output valid, output in_byte, output string_start, input ready);
	modport sink (input valid, input in_byte, input string_start, output ready);
endinterface

// File: src/u2u_out_if.sv
interface u2u_out_if;
	logic                      valid;
	logic                      ready;
	logic [u2u_pkg::UnitW-1:0] code_unit;
	logic                      out_of_range;

	modport source (output valid, output code_unit, output out_of_range, input ready);
	modport sink (input valid, input code_unit, input out_of_range, output ready);
endinterface

// File: src/u2u_in_stage.sv
module u2u_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	u2u_in_if.sink           bytes,
	input  logic             take,
	output u2u_pkg::stage_t  stage
);

	logic              valid_s1;
	u2u_pkg::in_item_t item_s1;
	logic              load;

	assign bytes.ready = !valid_s1 || take;
	assign load        = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.in_byte      <= bytes.in_byte;
			item_s1.string_start <= bytes.string_start;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

// File: src/u2u_decode.sv
module u2u_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  u2u_pkg::stage_t  stage,
	input  logic             out_free,
	output logic             take,
	output u2u_pkg::result_t result
);

	u2u_pkg::pend_t                pend_q, pend_eff, pend_nxt;
	logic [u2u_pkg::ValueW-1:0]    value_q, value_eff, value_nxt, emit_value;
	logic [u2u_pkg::ByteW-1:0]     b;
	logic                          emit;

	// Only a byte that finishes a character has to wait for the output register.
	assign take = stage.valid && (!emit || out_free);
	assign b    = stage.item.in_byte;

	always_comb begin
		// A new string drops whatever sequence was left open.
		pend_eff   = stage.item.string_start ? u2u_pkg::PEND_NONE : pend_q;
		value_eff  = stage.item.string_start ? '0 : value_q;
		pend_nxt   = pend_eff;
		value_nxt  = value_eff;
		emit       = 1'b0;
		emit_value = '0;
		if (pend_eff != u2u_pkg::PEND_NONE) begin
			emit_value = {value_eff[u2u_pkg::ValueW-u2u_pkg::ContW-1:0],
				b[u2u_pkg::ContW-1:0]};
			pend_nxt   = u2u_pkg::pend_t'(pend_eff - 2'd1);
			if (pend_nxt == u2u_pkg::PEND_NONE) begin
				emit      = 1'b1;
				value_nxt = '0;
			end else begin
				value_nxt = emit_value;
			end
		end else if (b == '0) begin
			// String terminator: nothing to do.
			emit = 1'b0;
		end else if (b < u2u_pkg::LeadTwoMin) begin
			emit       = 1'b1;
			emit_value = {{(u2u_pkg::ValueW-u2u_pkg::ByteW){1'b0}}, b};
		end else if (b < u2u_pkg::LeadThreeMin) begin
			pend_nxt  = u2u_pkg::PEND_ONE;
			value_nxt = {{(u2u_pkg::ValueW-5){1'b0}}, b[4:0]};
		end else if (b < u2u_pkg::LeadFourMin) begin
			pend_nxt  = u2u_pkg::PEND_TWO;
			value_nxt = {{(u2u_pkg::ValueW-4){1'b0}}, b[3:0]};
		end else begin
			pend_nxt  = u2u_pkg::PEND_THREE;
			value_nxt = {{(u2u_pkg::ValueW-3){1'b0}}, b[2:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= u2u_pkg::PEND_NONE;
			value_q <= '0;
		end else if (take) begin
			pend_q  <= pend_nxt;
			value_q <= value_nxt;
		end
	end

	always_comb begin
		result.load              = take && emit;
		result.item.out_of_range = |emit_value[u2u_pkg::ValueW-1:u2u_pkg::UnitW];
		result.item.code_unit    = result.item.out_of_range ? '0
			: emit_value[u2u_pkg::UnitW-1:0];
	end

endmodule

// File: src/u2u_out_reg.sv
module u2u_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  u2u_pkg::result_t result,
	output logic             out_free,
	u2u_out_if.source        units
);

	logic               valid_q;
	u2u_pkg::out_item_t item_q;

	assign out_free = !valid_q || units.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result.load) begin
			valid_q <= 1'b1;
		end else if (units.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.load) begin
			item_q <= result.item;
		end
	end

	assign units.valid        = valid_q;
	assign units.code_unit    = item_q.code_unit;
	assign units.out_of_range = item_q.out_of_range;

endmodule

// File: src/utf8_to_ucs2_decoder.sv
// UTF-8 byte stream in, UCS-2 code units out, one byte item per cycle unless stalled.
// A result goes from the input register through the combinational decoder to the output
// register. Throughput: one byte per cycle while the output register is free; bytes that
// do not finish a character keep flowing while a finished code unit waits to be taken.
// Reset (arst_n low, asynchronous) closes any open sequence and empties both registers.
module utf8_to_ucs2_decoder (
	input  logic       clk,
	input  logic       arst_n,
	u2u_in_if.sink     bytes,
	u2u_out_if.source  units
);

	u2u_pkg::stage_t  stage;
	u2u_pkg::result_t result;
	logic             take;
	logic             out_free;

	u2u_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.take   (take),
		.stage  (stage)
	);

	u2u_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage    (stage),
		.out_free (out_free),
		.take     (take),
		.result   (result)
	);

	u2u_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.out_free (out_free),
		.units    (units)
	);

endmodule

// File: verif/tb_utf8_to_ucs2_decoder.sv
module tb_utf8_to_ucs2_decoder;

	import u2u_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 9;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_PRINTS     = 40;
	localparam int DIR_ROWS       = 24;

	typedef struct {
		logic [ByteW-1:0] in_byte;
		logic             string_start;
		logic             pinned;
		logic [UnitW-1:0] pin_unit;
		logic             pin_oor;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	u2u_in_if  byte_ch ();
	u2u_out_if unit_ch ();

	utf8_to_ucs2_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.units  (unit_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Directed bytes; a typed result is given only where it is obvious.
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},  // terminator where a lead is due
		'{8'h01, 1'b0, 1'b1, 16'h0001, 1'b0},
		'{8'h7F, 1'b0, 1'b1, 16'h007F, 1'b0},
		'{8'hDF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hBF, 1'b0, 1'b1, 16'h07FF, 1'b0},
		'{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},  // stray following byte used as lead
		'{8'h00, 1'b0, 1'b1, 16'h0000, 1'b0},  // zero inside a sequence
		'{8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h82, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hAC, 1'b0, 1'b1, 16'h20AC, 1'b0},
		'{8'hEF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hBF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
		'{8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h90, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h80, 1'b0, 1'b1, 16'h0000, 1'b1},  // first value past 0xFFFF
		'{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hFF, 1'b0, 1'b1, 16'h0000, 1'b1},
		'{8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h82, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h41, 1'b1, 1'b1, 16'h0041, 1'b0}   // new string cuts the sequence
	};

	pend_t             seq_left;
	logic [ValueW-1:0] seq_value;
	out_item_t         pending_units [$];

	int  err_count   = 0;
	int  bytes_sent  = 0;
	int  units_seen  = 0;
	int  oor_seen    = 0;
	int  quiet_count = 0;
	bit  src_idle_en = 1'b0;
	bit  sink_idle_en = 1'b0;
	bit  hold_req    = 1'b0;

	out_item_t seen_unit;
	out_item_t want_unit;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < MAX_PRINTS)
			$display("mismatch in %s: got %h, expected %h", what, got, want);
		err_count++;
	endtask

	// Advances the decoder state by one byte; returns 1 when a code unit is due.
	function automatic logic decode_byte(input in_item_t item, output out_item_t unit);
		logic [ValueW-1:0] grown;
		unit = '0;
		if (item.string_start) begin
			seq_left  = PEND_NONE;
			seq_value = '0;
		end
		if (seq_left != PEND_NONE) begin
			grown    = {seq_value[ValueW-ContW-1:0], item.in_byte[ContW-1:0]};
			seq_left = pend_t'(seq_left - 2'd1);
			if (seq_left == PEND_NONE) begin
				if (grown[ValueW-1:UnitW] != '0) begin
					unit.out_of_range = 1'b1;
				end else begin
					unit.code_unit = grown[UnitW-1:0];
				end
				seq_value = '0;
				return 1'b1;
			end
			seq_value = grown;
			return 1'b0;
		end
		if (item.in_byte == '0)
			return 1'b0;
		if (item.in_byte < LeadTwoMin) begin
			unit.code_unit = {8'h00, item.in_byte};
			return 1'b1;
		end
		if (item.in_byte < LeadThreeMin) begin
			seq_value = ValueW'(item.in_byte[4:0]);
			seq_left  = PEND_ONE;
		end else if (item.in_byte < LeadFourMin) begin
			seq_value = ValueW'(item.in_byte[3:0]);
			seq_left  = PEND_TWO;
		end else begin
			seq_value = ValueW'(item.in_byte[2:0]);
			seq_left  = PEND_THREE;
		end
		return 1'b0;
	endfunction

	// Called at a falling edge; returns at the falling edge after the byte is taken.
	task automatic push_byte(input in_item_t item, input logic pinned, input out_item_t pin);
		out_item_t unit;
		logic      has_unit;
		if (src_idle_en && $urandom_range(0, 9) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		byte_ch.valid        <= 1'b1;
		byte_ch.in_byte      <= item.in_byte;
		byte_ch.string_start <= item.string_start;
		do @(posedge clk); while (!byte_ch.ready);
		has_unit = decode_byte(item, unit);
		if (pinned) begin
			if (!has_unit || unit != pin)
				flag_mismatch("directed row against predictor", 32'(unit), 32'(pin));
			unit     = pin;
			has_unit = 1'b1;
		end
		if (has_unit)
			pending_units.push_back(unit);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [ByteW-1:0] value, input logic start);
		in_item_t item;
		item.in_byte      = value;
		item.string_start = start;
		push_byte(item, 1'b0, '0);
	endtask

	// Mostly well-formed characters with random content, some cut short or noisy.
	task automatic send_random_char();
		int unsigned roll;
		int unsigned n_cont;
		logic [7:0]  lead;
		logic [7:0]  cont;
		logic        start;
		roll  = $urandom_range(0, 99);
		start = ($urandom_range(0, 15) == 0);
		if (roll < 3) begin
			send_byte(8'h00, 1'($urandom_range(0, 1)));
			return;
		end
		if (roll < 10) begin
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			return;
		end
		case ($urandom_range(0, 3))
			0: begin
				lead   = 8'($urandom_range(1, 127));
				n_cont = 0;
			end
			1: begin
				lead   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
				                                     : 8'($urandom_range(8'hC0, 8'hDF));
				n_cont = 1;
			end
			2: begin
				lead   = 8'($urandom_range(8'hE0, 8'hEF));
				n_cont = 2;
			end
			default: begin
				lead   = $urandom_range(0, 1) ? 8'hF0 : 8'($urandom_range(8'hF0, 8'hFF));
				n_cont = 3;
			end
		endcase
		// A short sequence makes the next lead byte be taken as a following byte.
		if (roll < 16 && n_cont != 0)
			n_cont = $urandom_range(0, n_cont - 1);
		send_byte(lead, start);
		for (int i = 0; i < n_cont; i++) begin
			cont = 8'h80 | 8'($urandom_range(0, 63));
			// Keep many four-byte values inside the 16-bit range.
			if (i == 0 && lead[7:3] == 5'b11110 && $urandom_range(0, 1))
				cont[5:4] = 2'b00;
			if ($urandom_range(0, 11) == 0)
				cont = 8'($urandom_range(0, 255));
			send_byte(cont, ($urandom_range(0, 39) == 0));
		end
	endtask

	task automatic run_random(input int n_bytes, input int hold_at);
		int goal;
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal) begin
			if (hold_at >= 0 && bytes_sent >= goal - n_bytes + hold_at && !hold_req) begin
				hold_req = 1'b1;
				hold_at  = -1;
			end
			send_random_char();
		end
	endtask

	// Output side: random stall bursts, plus one long hold on request.
	initial begin
		unit_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				unit_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				unit_ch.ready <= 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
				unit_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				unit_ch.ready <= 1'b1;
			end else begin
				unit_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (unit_ch.valid && unit_ch.ready) begin
				seen_unit.code_unit    = unit_ch.code_unit;
				seen_unit.out_of_range = unit_ch.out_of_range;
				units_seen++;
				if (seen_unit.out_of_range)
					oor_seen++;
				if (pending_units.size() == 0) begin
					flag_mismatch("unexpected code unit", 32'(seen_unit), 32'h0);
				end else begin
					want_unit = pending_units.pop_front();
					if (seen_unit.code_unit !== want_unit.code_unit)
						flag_mismatch("code_unit", 32'(seen_unit.code_unit),
							32'(want_unit.code_unit));
					if (seen_unit.out_of_range !== want_unit.out_of_range)
						flag_mismatch("out_of_range", 32'(seen_unit.out_of_range),
							32'(want_unit.out_of_range));
				end
			end
			if ((byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)) begin
				quiet_count = 0;
			end else begin
				quiet_count++;
			end
			if (quiet_count >= WATCHDOG_LIMIT) begin
				$display("watchdog: nothing moved for %0d cycles, %0d units outstanding",
					quiet_count, pending_units.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		in_item_t  item;
		out_item_t pin;
		arst_n               = 1'b0;
		byte_ch.valid        = 1'b0;
		byte_ch.in_byte      = '0;
		byte_ch.string_start = 1'b0;
		seq_left             = PEND_NONE;
		seq_value            = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sink_idle_en = 1'b1;
		for (int r = 0; r < DIR_ROWS; r++) begin
			item.in_byte      = dir_rows[r].in_byte;
			item.string_start = dir_rows[r].string_start;
			pin.code_unit     = dir_rows[r].pin_unit;
			pin.out_of_range  = dir_rows[r].pin_oor;
			push_byte(item, dir_rows[r].pinned, pin);
		end

		src_idle_en = 1'b1;
		run_random(400, 200);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		run_random(350, -1);
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		run_random(300, -1);
		// The tail runs at full rate on both sides.
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		run_random(200, -1);

		byte_ch.valid <= 1'b0;
		while (pending_units.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d UTF-8 bytes, checked %0d code units (%0d out of range).",
			bytes_sent, units_seen, oor_seen);
		$display("Stalls on both sides and one %0d-cycle output hold; %0d mismatches.",
			HOLD_CYCLES, err_count);
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
